/* rtl/ovmc_pkg.sv */
// Shared types and constants of the overlay mask compositor.
package ovmc_pkg;

  // Field widths fixed by the item format
  localparam int COORD_W    = 11;  // holds any clipped coordinate up to 2047
  localparam int SPAN_W     = 13;  // signed span arithmetic before clipping
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Queue sizes
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;

  // Input command codes
  localparam logic [1:0] CMD_CLEAR      = 2'd0;
  localparam logic [1:0] CMD_MARK_VIEW  = 2'd1;
  localparam logic [1:0] CMD_CLEAR_RECT = 2'd2;
  localparam logic [1:0] CMD_COMPOSITE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd4;

  // Configuration reset values and the reserved scale code
  localparam logic [1:0]  SCALE_SHIFT_RESET  = 2'd1;
  localparam logic [1:0]  SCALE_SHIFT_BAD    = 2'd3;
  localparam logic [10:0] VIEW_WIDTH_RESET   = 11'd640;
  localparam logic [9:0]  VIEW_HEIGHT_RESET  = 10'd400;

  // Operation carried from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FILL,
    OP_COMPOSITE
  } op_t;

  // Classified item; composite uses x0/y0 as column/row and skip as off-screen
  typedef struct packed {
    op_t                op;
    logic               fill_bit;
    logic               skip;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [PIX_W-1:0]   hires;
    logic [PIX_W-1:0]   classic;
  } entry_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR
  } state_t;

endpackage

/* rtl/ovmc_front.sv */
// Front end: configuration registers, item accept and classification with clipping.
module ovmc_front import ovmc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         push,
  input  logic                         stall,
  output logic                         full,
  input  logic [1:0]                   command,
  input  logic signed [10:0]           rect_x,
  input  logic signed [10:0]           rect_y,
  input  logic [9:0]                   rect_width,
  input  logic [9:0]                   rect_height,
  input  logic [10:0]                  pixel_x,
  input  logic [9:0]                   pixel_y,
  input  logic [PIX_W-1:0]             hires_pixel,
  input  logic [PIX_W-1:0]             classic_pixel,
  output logic                         enq,
  output entry_t                       entry
);

  localparam logic signed [SPAN_W-1:0] SW_S = SPAN_W'(SCREEN_WIDTH);
  localparam logic signed [SPAN_W-1:0] SH_S = SPAN_W'(SCREEN_HEIGHT);

  logic [1:0]  scale_shift;
  logic [10:0] view_left;
  logic [9:0]  view_top;
  logic [10:0] view_width;
  logic [9:0]  view_height;

  logic signed [SPAN_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [SPAN_W-1:0] cx0, cx1, cy0, cy1;
  logic                     fill_empty;
  logic                     is_fill;
  logic [COORD_W-1:0]       px;
  logic [9:0]               py;
  logic                     on_screen;

  assign cfg_ready = 1'b1;

  // Write configuration; the reserved scale code leaves the register alone
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_shift <= SCALE_SHIFT_RESET;
      view_left   <= '0;
      view_top    <= '0;
      view_width  <= VIEW_WIDTH_RESET;
      view_height <= VIEW_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCALE_SHIFT: begin
          if (cfg_data[1:0] != SCALE_SHIFT_BAD) scale_shift <= cfg_data[1:0];
        end
        REG_VIEW_LEFT:   view_left   <= cfg_data;
        REG_VIEW_TOP:    view_top    <= cfg_data[9:0];
        REG_VIEW_WIDTH:  view_width  <= cfg_data;
        REG_VIEW_HEIGHT: view_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Form the unclipped rectangle: scaled view or signed overlay rectangle
  always_comb begin
    if (command == CMD_MARK_VIEW) begin
      lo_x = $signed({2'b00, 11'(view_left >> scale_shift)});
      hi_x = lo_x + $signed({2'b00, 11'(view_width >> scale_shift)});
      lo_y = $signed({3'b000, 10'(view_top >> scale_shift)});
      hi_y = lo_y + $signed({3'b000, 10'(view_height >> scale_shift)});
    end else begin
      lo_x = $signed({{2{rect_x[10]}}, rect_x});
      hi_x = lo_x + $signed({3'b000, rect_width});
      lo_y = $signed({{2{rect_y[10]}}, rect_y});
      hi_y = lo_y + $signed({3'b000, rect_height});
    end
  end

  // Clip to the screen and detect an empty result
  always_comb begin
    cx0 = (lo_x < 0) ? '0 : lo_x;
    cy0 = (lo_y < 0) ? '0 : lo_y;
    cx1 = (hi_x > SW_S) ? SW_S : hi_x;
    cy1 = (hi_y > SH_S) ? SH_S : hi_y;
    fill_empty = (cx1 <= cx0) || (cy1 <= cy0);
  end

  // Scale the composite position down to the classic grid
  always_comb begin
    px        = pixel_x >> scale_shift;
    py        = pixel_y >> scale_shift;
    on_screen = (px < COORD_W'(SCREEN_WIDTH)) && ({1'b0, py} < COORD_W'(SCREEN_HEIGHT));
  end

  // Build the queue entry
  always_comb begin
    entry          = '0;
    entry.hires    = hires_pixel;
    entry.classic  = classic_pixel;
    is_fill        = 1'b0;
    case (command)
      CMD_CLEAR: begin
        entry.op = OP_CLEAR;
      end
      CMD_MARK_VIEW, CMD_CLEAR_RECT: begin
        is_fill        = 1'b1;
        entry.op       = OP_FILL;
        entry.fill_bit = (command == CMD_MARK_VIEW);
        entry.x0       = cx0[COORD_W-1:0];
        entry.x1       = cx1[COORD_W-1:0];
        entry.y0       = cy0[COORD_W-1:0];
        entry.y1       = cy1[COORD_W-1:0];
      end
      default: begin
        entry.op   = OP_COMPOSITE;
        entry.skip = !on_screen;
        entry.x0   = on_screen ? px : '0;
        entry.y0   = on_screen ? {1'b0, py} : '0;
      end
    endcase
  end

  // Accept while the queue has room and the reset clearing pass is over; drop fills that clip to nothing
  assign full = stall;
  assign enq  = push && !stall && !(is_fill && fill_empty);

endmodule

/* rtl/ovmc_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module ovmc_cmd_fifo import ovmc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   q_full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   q_valid
);

  entry_t             slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp;
  logic [CMDQ_AW-1:0] rp;
  logic [CMDQ_AW:0]   count;

  assign q_full  = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = slots[rp];

  // Store payload
  always_ff @(posedge clk) begin
    if (wr_en) slots[wp] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr_en) wp <= wp + 1'b1;
      if (rd_en) rp <= rp + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/ovmc_back.sv */
// Back end: mask memory, row sequencer for clear and fill, composite pipe and result queue.
module ovmc_back import ovmc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           head,
  input  logic             hd_valid,
  output logic             hd_pop,
  output logic             init_busy,
  output logic             empty,
  input  logic             pop,
  output logic [PIX_W-1:0] out_pixel
);

  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int YW = $clog2(SCREEN_HEIGHT);

  // Mask memory, one screen row per word
  logic [SCREEN_WIDTH-1:0] mask_mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0] rdata;
  logic                    mem_re;
  logic [YW-1:0]           mem_raddr;
  logic                    mem_we;
  logic [SCREEN_WIDTH-1:0] mem_wdata;

  state_t                  state, state_next;
  logic [YW-1:0]           row, row_next;
  logic                    init;
  logic                    init_next;
  logic                    take_fill;
  logic                    issue;
  logic                    can_issue;
  logic [COORD_W-1:0]      f_y1;
  logic                    f_bit;
  logic [SCREEN_WIDTH-1:0] col_mask, col_mask_next;

  // Composite read stage
  logic                    bv;
  logic [XW-1:0]           b_col;
  logic                    b_skip;
  logic [PIX_W-1:0]        b_hires;
  logic [PIX_W-1:0]        b_classic;
  logic [PIX_W-1:0]        b_out;

  // Result queue
  logic [PIX_W-1:0]        oq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]      owp;
  logic [OUTQ_AW-1:0]      orp;
  logic [OUTQ_AW:0]        oc;
  logic                    opop;

  assign init_busy = init;

  // Leave room in the result queue for the read in flight
  assign can_issue = (oc + (OUTQ_AW+1)'(bv)) < (OUTQ_AW+1)'(OUTQ_DEPTH);

  // Column mask of the fill span
  always_comb begin
    for (int i = 0; i < SCREEN_WIDTH; i++) begin
      col_mask_next[i] = (COORD_W'(i) >= head.x0) && (COORD_W'(i) < head.x1);
    end
  end

  // Sequence clears, fills and composite reads
  always_comb begin
    state_next = state;
    row_next   = row;
    init_next  = init;
    hd_pop     = 1'b0;
    take_fill  = 1'b0;
    issue      = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = row;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    case (state)
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (row == YW'(SCREEN_HEIGHT - 1)) begin
          state_next = ST_IDLE;
          row_next   = '0;
          init_next  = 1'b0;
        end else begin
          row_next = row + 1'b1;
        end
      end
      ST_IDLE: begin
        if (hd_valid) begin
          case (head.op)
            OP_CLEAR: begin
              hd_pop     = 1'b1;
              row_next   = '0;
              state_next = ST_SWEEP;
            end
            OP_FILL: begin
              hd_pop     = 1'b1;
              take_fill  = 1'b1;
              row_next   = head.y0[YW-1:0];
              state_next = ST_FILL_RD;
            end
            OP_COMPOSITE: begin
              if (can_issue) begin
                hd_pop    = 1'b1;
                issue     = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = head.y0[YW-1:0];
              end
            end
            default: hd_pop = 1'b1;
          endcase
        end
      end
      ST_FILL_RD: begin
        mem_re     = 1'b1;
        state_next = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = f_bit ? (rdata | col_mask) : (rdata & ~col_mask);
        if ((COORD_W'(row) + COORD_W'(1)) == f_y1) begin
          state_next = ST_IDLE;
        end else begin
          row_next   = row + 1'b1;
          state_next = ST_FILL_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold sequencer state; start with a clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      row   <= '0;
      init  <= 1'b1;
    end else begin
      state <= state_next;
      row   <= row_next;
      init  <= init_next;
    end
  end

  // Latch fill span
  always_ff @(posedge clk) begin
    if (take_fill) begin
      f_y1     <= head.y1;
      f_bit    <= head.fill_bit;
      col_mask <= col_mask_next;
    end
  end

  // Access the mask memory
  always_ff @(posedge clk) begin
    if (mem_we) mask_mem[row] <= mem_wdata;
    if (mem_re) rdata <= mask_mem[mem_raddr];
  end

  // Carry composite payload alongside the read
  always_ff @(posedge clk) begin
    if (rst) bv <= 1'b0;
    else     bv <= issue;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_col     <= head.x0[XW-1:0];
      b_skip    <= head.skip;
      b_hires   <= head.hires;
      b_classic <= head.classic;
    end
  end

  // Pick rendered pixel where the mask is set and the position is on screen
  assign b_out = (!b_skip && rdata[b_col]) ? b_hires : b_classic;

  // Result queue toward the output port
  assign opop      = pop && (oc != '0);
  assign empty     = (oc == '0);
  assign out_pixel = oq[orp];

  always_ff @(posedge clk) begin
    if (bv) oq[owp] <= b_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0;
      orp <= '0;
      oc  <= '0;
    end else begin
      if (bv)   owp <= owp + 1'b1;
      if (opop) orp <= orp + 1'b1;
      case ({bv, opop})
        2'b10:   oc <= oc + 1'b1;
        2'b01:   oc <= oc - 1'b1;
        default: oc <= oc;
      endcase
    end
  end

endmodule

/* rtl/overlay_mask_compositor_top.sv */
// Top level of the overlay mask compositor: front end, command queue and back end.
//
// Composite items run at one item per cycle once the queue is primed, while the result
// queue has room and no clear or fill is running, limited by the single registered read
// port of the row-wide mask memory; a composite result passes through the command
// queue and the registered mask read before it enters the output queue. Mark view and
// clear rectangle read-modify-write the row word of each screen row that the clipped
// rectangle covers; one that clips to nothing is dropped at the input. Clear mask
// writes each row of the mask in turn. After reset, full stays high during a clearing
// pass over the mask; configuration writes are taken throughout.
module overlay_mask_compositor_top import ovmc_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            command,
  input  logic signed [10:0]    rect_x,
  input  logic signed [10:0]    rect_y,
  input  logic [9:0]            rect_width,
  input  logic [9:0]            rect_height,
  input  logic [10:0]           pixel_x,
  input  logic [9:0]            pixel_y,
  input  logic [PIX_W-1:0]      hires_pixel,
  input  logic [PIX_W-1:0]      classic_pixel,
  output logic                  empty,
  input  logic                  pop,
  output logic [PIX_W-1:0]      out_pixel
);

  logic   enq;
  entry_t enq_entry;
  logic   q_full;
  logic   q_valid;
  entry_t head;
  logic   hd_pop;
  logic   init_busy;

  ovmc_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .stall         (q_full || init_busy),
    .full          (full),
    .command       (command),
    .rect_x        (rect_x),
    .rect_y        (rect_y),
    .rect_width    (rect_width),
    .rect_height   (rect_height),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .hires_pixel   (hires_pixel),
    .classic_pixel (classic_pixel),
    .enq           (enq),
    .entry         (enq_entry)
  );

  ovmc_cmd_fifo u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (enq),
    .wr_data (enq_entry),
    .q_full  (q_full),
    .rd_en   (hd_pop),
    .rd_data (head),
    .q_valid (q_valid)
  );

  ovmc_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .hd_valid  (q_valid),
    .hd_pop    (hd_pop),
    .init_busy (init_busy),
    .empty     (empty),
    .pop       (pop),
    .out_pixel (out_pixel)
  );

endmodule

/* rtl/ovmc_checker.sv */
// Port-level checks on the overlay mask compositor and their binding to the top level.
module ovmc_checker import ovmc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cfg_ready,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [PIX_W-1:0] out_pixel
);

  // Reset starts the clearing pass with nothing queued
  a_reset_state: assert property (@(posedge clk) rst |=> full && empty)
    else $error("full and empty not both high after reset");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready dropped");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_pixel))
    else $error("waiting result changed before pop");

endmodule

bind overlay_mask_compositor_top ovmc_checker u_ovmc_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_pixel (out_pixel)
);
